### sv/ahfc_pkg.sv
// ----------------------------------------------------------------------------
// ahfc_pkg - shared types and constants of the ascii hex frame codec
// Word layouts of both channels, frame characters, result kinds, status
// codes and the hex digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ahfc_pkg;

  // command length limit and derived counter width (saturates at limit + 1)
  localparam int unsigned MAX_CMD_BYTES = 261;
  localparam int unsigned CMD_CNT_W     = $clog2(MAX_CMD_BYTES + 2);

  // result words one input word can cause
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // frame characters and check seed
  localparam logic [7:0] CH_STX    = 8'h02;
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CHK_SEED  = 8'h01;
  localparam logic [7:0] LEN_EXTEND = 8'hff;

  // shortest acceptable reply, STX and ETX included
  localparam logic [15:0] MIN_REPLY_CHARS = 16'd12;
  localparam logic [15:0] CNT_SAT         = 16'hffff;

  // reply fields by byte position
  localparam logic [15:0] IDX_SW1     = 16'd1;
  localparam logic [15:0] IDX_SW2     = 16'd2;
  localparam logic [15:0] IDX_LEN     = 16'd3;
  localparam logic [15:0] IDX_LEN_HI  = 16'd4;
  localparam logic [15:0] IDX_LEN_LO  = 16'd5;
  localparam logic [15:0] HDR_SHORT   = 16'd4;
  localparam logic [15:0] HDR_EXT     = 16'd6;

  // result kinds
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // end status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_FRAME = 3'd2;
  localparam logic [2:0] ST_BAD_CHECK = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_REPLY_LEN = 2'd0;
  localparam logic [15:0] MAX_REPLY_LEN_RST = 16'd265;

  // mode codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic       last;
  } ahfc_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [7:0]  sw_one;
    logic [7:0]  sw_two;
    logic [15:0] reply_length;
    logic [2:0]  status;
    logic        last_out;
  } ahfc_out_t;

  // upper-case hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
  endfunction

  // lenient digit value: any character maps to some nibble
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (d > 8'd9) begin
      d = d - 8'd7;
    end
    nibble_of = d[3:0];
  endfunction

  // frame character word
  function automatic ahfc_out_t char_word(input logic [7:0] ch, input logic lst);
    ahfc_out_t w;
    w          = '0;
    w.kind     = KIND_CHAR;
    w.value    = ch;
    w.last_out = lst;
    char_word  = w;
  endfunction

endpackage

`default_nettype wire

### sv/ascii_hex_frame_codec.sv
// ----------------------------------------------------------------------------
// ascii_hex_frame_codec - STX/ETX ascii hex framing with xor check
// Encodes command bytes into hex frames and decodes hex reply frames into
// payload bytes and an end status word.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries func, data and last; a word is taken when in_valid is
//   high and in_stall is low. Each input word is worked out into a list of
//   up to eight result words, which drain one per cycle, while out_stall is
//   low, through the out_word register (out_valid / out_stall).
//   The first result of a word is registered in the pending list when the
//   word is taken, and then in the out_word register.
//   The single output register passes one result per cycle while out_stall
//   is low: a decode character gives at most one result, an encoded command
//   byte two hex characters, plus STX, '0' and '1' at the frame start and
//   the check and ETX at the end of a frame. A new word is taken in the same
//   cycle the last pending result moves to the output register.
//   max_reply_len sits at byte address 0 of the APB port; write it only while
//   the block is idle.
//   Reset clears all framing state, sets max_reply_len to 265 and empties the
//   output. While out_stall is high a valid output word holds and in_stall rises
//   as soon as the pending list cannot drain.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_hex_frame_codec (
  input  wire                  clk,
  input  wire                  rst_n,
  // input words
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire ahfc_pkg::ahfc_in_t in_word,
  // result words
  output logic                 out_valid,
  input  wire                  out_stall,
  output ahfc_pkg::ahfc_out_t  out_word,
  // configuration
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [1:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // framing state
  logic [7:0]  rchk_r, rchk_nxt;
  logic [15:0] char_cnt_r, char_cnt_nxt;
  logic [15:0] byte_idx_r, byte_idx_nxt;
  logic [3:0]  hi_nib_r, hi_nib_nxt;
  logic        half_r, half_nxt;
  logic        first_r, first_nxt;
  logic        hdr_bad_r, hdr_bad_nxt;
  logic [7:0]  sw1_r, sw1_nxt;
  logic [7:0]  sw2_r, sw2_nxt;
  logic        ext_r, ext_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [ahfc_pkg::CMD_CNT_W-1:0] cmd_cnt_r, cmd_cnt_nxt;
  logic [15:0] max_len_r;

  // pending result list and output register
  ahfc_pkg::ahfc_out_t lst_r   [ahfc_pkg::MAX_RESULTS];
  ahfc_pkg::ahfc_out_t lst_nxt [ahfc_pkg::MAX_RESULTS];
  logic [ahfc_pkg::RES_CNT_W-1:0] cnt_r, n_nxt;
  logic                out_valid_r;
  ahfc_pkg::ahfc_out_t out_word_r;

  logic in_acc, out_free, pop;

  // working values
  logic [ahfc_pkg::CMD_CNT_W-1:0] enc_cc, enc_cc_n;
  logic [7:0]  enc_chk, dec_chk, dec_b;
  logic        enc_emit;
  logic [15:0] hdr_len, pay_off;
  logic [2:0]  dec_st;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (cnt_r != '0) && out_free;
  assign in_stall = !((cnt_r == '0) ||
                      ((cnt_r == ahfc_pkg::RES_CNT_W'(1)) && pop));
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == ahfc_pkg::REG_MAX_REPLY_LEN) begin
      prdata = {16'd0, max_len_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ahfc_pkg::MAX_REPLY_LEN_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ahfc_pkg::REG_MAX_REPLY_LEN) begin
      max_len_r <= pwdata[15:0];
    end
  end

  // per-word processing: next state and result list
  always_comb begin
    rchk_nxt     = rchk_r;
    char_cnt_nxt = char_cnt_r;
    byte_idx_nxt = byte_idx_r;
    hi_nib_nxt   = hi_nib_r;
    half_nxt     = half_r;
    first_nxt    = first_r;
    hdr_bad_nxt  = hdr_bad_r;
    sw1_nxt      = sw1_r;
    sw2_nxt      = sw2_r;
    ext_nxt      = ext_r;
    decl_len_nxt = decl_len_r;
    cmd_cnt_nxt  = cmd_cnt_r;
    for (int i = 0; i < int'(ahfc_pkg::MAX_RESULTS); i++) begin
      lst_nxt[i] = '0;
    end
    n_nxt    = '0;
    enc_cc   = first_r ? cmd_cnt_r : '0;
    enc_chk  = first_r ? rchk_r : ahfc_pkg::CHK_SEED;
    enc_cc_n = (enc_cc <= ahfc_pkg::CMD_CNT_W'(ahfc_pkg::MAX_CMD_BYTES)) ?
               enc_cc + ahfc_pkg::CMD_CNT_W'(1) : enc_cc;
    enc_emit = enc_cc_n <= ahfc_pkg::CMD_CNT_W'(ahfc_pkg::MAX_CMD_BYTES);
    dec_chk  = first_r ? ahfc_pkg::CHK_SEED : rchk_r;
    dec_b    = {hi_nib_r, ahfc_pkg::nibble_of(in_word.data)};
    hdr_len  = ext_r ? ahfc_pkg::HDR_EXT : ahfc_pkg::HDR_SHORT;
    pay_off  = byte_idx_r - hdr_len;
    if (char_cnt_r < ahfc_pkg::MIN_REPLY_CHARS - 16'd1) begin
      dec_st = ahfc_pkg::ST_SHORT;
    end else if (hdr_bad_r) begin
      dec_st = ahfc_pkg::ST_BAD_FRAME;
    end else if (dec_chk != 8'd0) begin
      dec_st = ahfc_pkg::ST_BAD_CHECK;
    end else begin
      dec_st = ahfc_pkg::ST_OK;
    end

    if (in_acc) begin
      if (in_word.func == ahfc_pkg::FUNC_ENCODE) begin
        // encode: drop any partial reply
        if (char_cnt_r != '0) begin
          char_cnt_nxt = '0;
          byte_idx_nxt = '0;
          hi_nib_nxt   = '0;
          half_nxt     = 1'b0;
          hdr_bad_nxt  = 1'b0;
          sw1_nxt      = '0;
          sw2_nxt      = '0;
          ext_nxt      = 1'b0;
          decl_len_nxt = '0;
        end
        // frame start
        if (!first_r) begin
          lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] =
            ahfc_pkg::char_word(ahfc_pkg::CH_STX, 1'b0);
          n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
          lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] =
            ahfc_pkg::char_word(ahfc_pkg::CH_ZERO, 1'b0);
          n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
          lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] =
            ahfc_pkg::char_word(ahfc_pkg::CH_ONE, 1'b0);
          n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
        end
        // command byte as two hex characters
        if (enc_emit) begin
          enc_chk = enc_chk ^ in_word.data;
          lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] =
            ahfc_pkg::char_word(ahfc_pkg::hex_char(in_word.data[7:4]), 1'b0);
          n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
          lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] =
            ahfc_pkg::char_word(ahfc_pkg::hex_char(in_word.data[3:0]), 1'b0);
          n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
        end
        // frame end: check and ETX, or too-long status
        if (in_word.last) begin
          if (!enc_emit) begin
            lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] = '0;
            lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]].kind     = ahfc_pkg::KIND_STATUS;
            lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]].status   = ahfc_pkg::ST_TOO_LONG;
            lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]].last_out = 1'b1;
            n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
          end else begin
            lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] =
              ahfc_pkg::char_word(ahfc_pkg::hex_char(enc_chk[7:4]), 1'b0);
            n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
            lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] =
              ahfc_pkg::char_word(ahfc_pkg::hex_char(enc_chk[3:0]), 1'b0);
            n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
            lst_nxt[n_nxt[ahfc_pkg::RES_IDX_W-1:0]] =
              ahfc_pkg::char_word(ahfc_pkg::CH_ETX, 1'b1);
            n_nxt = n_nxt + ahfc_pkg::RES_CNT_W'(1);
          end
          first_nxt   = 1'b0;
          cmd_cnt_nxt = '0;
          rchk_nxt    = ahfc_pkg::CHK_SEED;
        end else begin
          first_nxt   = 1'b1;
          cmd_cnt_nxt = enc_cc_n;
          rchk_nxt    = enc_chk;
        end
      end else begin
        // decode: drop any open command frame
        if (first_r) begin
          first_nxt   = 1'b0;
          cmd_cnt_nxt = '0;
          rchk_nxt    = ahfc_pkg::CHK_SEED;
        end
        if (in_word.data == ahfc_pkg::CH_ETX) begin
          // end of reply: one status word, then clear
          lst_nxt[0]              = '0;
          lst_nxt[0].kind         = ahfc_pkg::KIND_STATUS;
          lst_nxt[0].sw_one       = sw1_r;
          lst_nxt[0].sw_two       = sw2_r;
          lst_nxt[0].reply_length = decl_len_r;
          lst_nxt[0].status       = dec_st;
          lst_nxt[0].last_out     = 1'b1;
          n_nxt        = ahfc_pkg::RES_CNT_W'(1);
          char_cnt_nxt = '0;
          byte_idx_nxt = '0;
          hi_nib_nxt   = '0;
          half_nxt     = 1'b0;
          hdr_bad_nxt  = 1'b0;
          sw1_nxt      = '0;
          sw2_nxt      = '0;
          ext_nxt      = 1'b0;
          decl_len_nxt = '0;
        end else if (char_cnt_r == '0) begin
          // first character should be STX
          hdr_bad_nxt  = (in_word.data != ahfc_pkg::CH_STX);
          rchk_nxt     = 8'd0;
          char_cnt_nxt = 16'd1;
        end else begin
          if (char_cnt_r != ahfc_pkg::CNT_SAT) begin
            char_cnt_nxt = char_cnt_r + 16'd1;
          end
          if (!half_r) begin
            hi_nib_nxt = ahfc_pkg::nibble_of(in_word.data);
            half_nxt   = 1'b1;
          end else begin
            // complete byte
            half_nxt = 1'b0;
            rchk_nxt = dec_chk ^ dec_b;
            if (byte_idx_r == ahfc_pkg::IDX_SW1) begin
              sw1_nxt = dec_b;
            end else if (byte_idx_r == ahfc_pkg::IDX_SW2) begin
              sw2_nxt = dec_b;
            end else if (byte_idx_r == ahfc_pkg::IDX_LEN) begin
              if (dec_b == ahfc_pkg::LEN_EXTEND) begin
                ext_nxt = 1'b1;
              end else begin
                decl_len_nxt = {8'd0, dec_b};
              end
            end else if (ext_r && byte_idx_r == ahfc_pkg::IDX_LEN_HI) begin
              decl_len_nxt = {dec_b, 8'd0};
            end else if (ext_r && byte_idx_r == ahfc_pkg::IDX_LEN_LO) begin
              decl_len_nxt = {decl_len_r[15:8], decl_len_r[7:0] | dec_b};
            end else if (byte_idx_r >= hdr_len && byte_idx_r != ahfc_pkg::CNT_SAT &&
                         pay_off < decl_len_r && pay_off < max_len_r) begin
              lst_nxt[0]       = '0;
              lst_nxt[0].kind  = ahfc_pkg::KIND_BYTE;
              lst_nxt[0].value = dec_b;
              n_nxt            = ahfc_pkg::RES_CNT_W'(1);
            end
            if (byte_idx_r != ahfc_pkg::CNT_SAT) begin
              byte_idx_nxt = byte_idx_r + 16'd1;
            end
          end
        end
      end
    end
  end

  // framing state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rchk_r     <= ahfc_pkg::CHK_SEED;
      char_cnt_r <= '0;
      byte_idx_r <= '0;
      hi_nib_r   <= '0;
      half_r     <= 1'b0;
      first_r    <= 1'b0;
      hdr_bad_r  <= 1'b0;
      sw1_r      <= '0;
      sw2_r      <= '0;
      ext_r      <= 1'b0;
      decl_len_r <= '0;
      cmd_cnt_r  <= '0;
    end else begin
      rchk_r     <= rchk_nxt;
      char_cnt_r <= char_cnt_nxt;
      byte_idx_r <= byte_idx_nxt;
      hi_nib_r   <= hi_nib_nxt;
      half_r     <= half_nxt;
      first_r    <= first_nxt;
      hdr_bad_r  <= hdr_bad_nxt;
      sw1_r      <= sw1_nxt;
      sw2_r      <= sw2_nxt;
      ext_r      <= ext_nxt;
      decl_len_r <= decl_len_nxt;
      cmd_cnt_r  <= cmd_cnt_nxt;
    end
  end

  // pending list count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= n_nxt;
    end else if (pop) begin
      cnt_r <= cnt_r - ahfc_pkg::RES_CNT_W'(1);
    end
  end

  // pending list payload: load on accept, shift toward the head on pop
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < int'(ahfc_pkg::MAX_RESULTS); i++) begin
        lst_r[i] <= lst_nxt[i];
      end
    end else if (pop) begin
      for (int i = 0; i < int'(ahfc_pkg::MAX_RESULTS) - 1; i++) begin
        lst_r[i] <= lst_r[i+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= (cnt_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word_r <= lst_r[0];
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ahfc_pkg::RES_CNT_W'(ahfc_pkg::MAX_RESULTS))
    else $error("pending list count out of range");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.kind == ahfc_pkg::KIND_STATUS) |-> out_word_r.last_out)
    else $error("status word without last_out");

  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.kind == ahfc_pkg::KIND_CHAR ||
                     out_word_r.kind == ahfc_pkg::KIND_BYTE ||
                     out_word_r.kind == ahfc_pkg::KIND_STATUS))
    else $error("unknown result kind");

  a_cmd_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_cnt_r <= ahfc_pkg::CMD_CNT_W'(ahfc_pkg::MAX_CMD_BYTES + 1))
    else $error("command count past saturation");

  a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(first_r && char_cnt_r != '0))
    else $error("encode and decode frames open together");

endmodule

`default_nettype wire

### tb/ahfc_checker.sv
// ----------------------------------------------------------------------------
// ahfc_checker - result checker for the ascii hex frame codec
// Watches the input, result and APB channels, runs its own model of the
// framing and deframing rules on every accepted input word and compares each
// accepted result word, field by field, with the oldest word still due.
// ----------------------------------------------------------------------------
module ahfc_checker
  import ahfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  ahfc_in_t   in_word,
  input  logic       out_valid,
  input  logic       out_stall,
  input  ahfc_out_t  out_word,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic       pready,
  output int         fail_count,
  output int         results_due
);

  localparam logic [1:0] MAX_LEN_ADDR = 2'(4 * REG_MAX_REPLY_LEN);

  // result words still to come, oldest first
  ahfc_out_t codec_results [$];
  int errors = 0;

  // model state
  logic [15:0] max_len;
  logic [7:0]  xor_acc;
  logic [15:0] char_cnt;
  logic [15:0] byte_idx;
  logic [3:0]  hi_nib;
  logic        half;
  logic        frame_open;
  logic        hdr_bad;
  logic [7:0]  sw1_q;
  logic [7:0]  sw2_q;
  logic        ext_len;
  logic [15:0] decl_len;
  logic [8:0]  cmd_cnt;

  // upper-case hex character for a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n > 4'd9) return 8'h41 + 8'(n - 4'd10);
    return CH_ZERO + 8'(n);
  endfunction

  // lenient digit: anything maps to some nibble
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return (d > 8'd9) ? 4'(d - 8'd7) : d[3:0];
  endfunction

  task automatic add_result(input logic [1:0] k, input logic [7:0] v, input logic [7:0] s1,
                            input logic [7:0] s2, input logic [15:0] len,
                            input logic [2:0] st, input logic lst);
    ahfc_out_t r;
    r.kind         = k;
    r.value        = v;
    r.sw_one       = s1;
    r.sw_two       = s2;
    r.reply_length = len;
    r.status       = st;
    r.last_out     = lst;
    codec_results.push_back(r);
  endtask

  task automatic add_char(input logic [7:0] ch, input logic lst);
    add_result(KIND_CHAR, ch, 8'd0, 8'd0, 16'd0, ST_OK, lst);
  endtask

  task automatic clear_reply();
    char_cnt = '0;
    byte_idx = '0;
    hi_nib   = '0;
    half     = 1'b0;
    hdr_bad  = 1'b0;
    sw1_q    = '0;
    sw2_q    = '0;
    ext_len  = 1'b0;
    decl_len = '0;
  endtask

  task automatic clear_command();
    frame_open = 1'b0;
    cmd_cnt    = '0;
    xor_acc    = CHK_SEED;
  endtask

  // one accepted word through the codec
  task automatic run_codec(input ahfc_in_t w);
    logic [7:0]  b;
    logic [15:0] hdr;
    logic [15:0] cap;
    logic [2:0]  st;
    if (w.func == FUNC_ENCODE) begin
      if (char_cnt != 0) clear_reply();
      // frame start
      if (!frame_open) begin
        frame_open = 1'b1;
        cmd_cnt    = '0;
        xor_acc    = CHK_SEED;
        add_char(CH_STX, 1'b0);
        add_char(CH_ZERO, 1'b0);
        add_char(CH_ONE, 1'b0);
      end
      // command byte, dropped past the length limit
      if (cmd_cnt <= 9'(MAX_CMD_BYTES)) cmd_cnt = cmd_cnt + 9'd1;
      if (cmd_cnt <= 9'(MAX_CMD_BYTES)) begin
        xor_acc = xor_acc ^ w.data;
        add_char(hex_digit(w.data[7:4]), 1'b0);
        add_char(hex_digit(w.data[3:0]), 1'b0);
      end
      // frame end: check and ETX, or the too-long status
      if (w.last) begin
        if (cmd_cnt > 9'(MAX_CMD_BYTES)) begin
          add_result(KIND_STATUS, 8'd0, 8'd0, 8'd0, 16'd0, ST_TOO_LONG, 1'b1);
        end else begin
          add_char(hex_digit(xor_acc[7:4]), 1'b0);
          add_char(hex_digit(xor_acc[3:0]), 1'b0);
          add_char(CH_ETX, 1'b1);
        end
        clear_command();
      end
    end else begin
      if (frame_open) clear_command();
      if (w.data == CH_ETX) begin
        // end of reply
        if (char_cnt < MIN_REPLY_CHARS - 16'd1) st = ST_SHORT;
        else if (hdr_bad) st = ST_BAD_FRAME;
        else if (xor_acc != 8'd0) st = ST_BAD_CHECK;
        else st = ST_OK;
        add_result(KIND_STATUS, 8'd0, sw1_q, sw2_q, decl_len, st, 1'b1);
        clear_reply();
      end else if (char_cnt == 0) begin
        // first character of a reply
        hdr_bad  = (w.data != CH_STX);
        xor_acc  = 8'd0;
        char_cnt = 16'd1;
      end else begin
        if (char_cnt < CNT_SAT) char_cnt = char_cnt + 16'd1;
        if (!half) begin
          hi_nib = digit_value(w.data);
          half   = 1'b1;
        end else begin
          half    = 1'b0;
          b       = {hi_nib, digit_value(w.data)};
          hdr     = ext_len ? HDR_EXT : HDR_SHORT;
          xor_acc = xor_acc ^ b;
          if (byte_idx == IDX_SW1) begin
            sw1_q = b;
          end else if (byte_idx == IDX_SW2) begin
            sw2_q = b;
          end else if (byte_idx == IDX_LEN) begin
            if (b == LEN_EXTEND) ext_len = 1'b1;
            else decl_len = {8'd0, b};
          end else if (ext_len && byte_idx == IDX_LEN_HI) begin
            decl_len = {b, 8'd0};
          end else if (ext_len && byte_idx == IDX_LEN_LO) begin
            decl_len = decl_len | {8'd0, b};
          end else if (byte_idx >= hdr && byte_idx < CNT_SAT) begin
            // payload, up to the declared length and the configured cap
            cap = (decl_len < max_len) ? decl_len : max_len;
            if (byte_idx - hdr < cap)
              add_result(KIND_BYTE, b, 8'd0, 8'd0, 16'd0, ST_OK, 1'b0);
          end
          if (byte_idx < CNT_SAT) byte_idx = byte_idx + 16'd1;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // watch all three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      max_len = MAX_REPLY_LEN_RST;
      clear_reply();
      clear_command();
      codec_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAX_LEN_ADDR)
        max_len = pwdata[15:0];
      if (out_valid && !out_stall) begin
        if (codec_results.size() == 0) begin
          errors++;
          $display("%0t: expected no result word, got %p", $time, out_word);
        end else begin
          ahfc_out_t e;
          e = codec_results.pop_front();
          check_field("kind", 16'(e.kind), 16'(out_word.kind));
          check_field("value", 16'(e.value), 16'(out_word.value));
          check_field("sw_one", 16'(e.sw_one), 16'(out_word.sw_one));
          check_field("sw_two", 16'(e.sw_two), 16'(out_word.sw_two));
          check_field("reply_length", e.reply_length, out_word.reply_length);
          check_field("status", 16'(e.status), 16'(out_word.status));
          check_field("last_out", 16'(e.last_out), 16'(out_word.last_out));
        end
      end
      if (in_valid && !in_stall) run_codec(in_word);
    end
    results_due <= codec_results.size();
    fail_count  <= errors;
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - top level for the ascii hex frame codec
// Drives command bytes and reply characters in random bursts, stalls the
// result side on its own pattern and sweeps max_reply_len over several
// values; the checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
  import ahfc_pkg::*;

  localparam int unsigned LIMIT = 3_000_000;
  localparam int ITEM_TARGET  = 120;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int ALL_BYTES    = 1 << 30;
  localparam logic [1:0] MAX_LEN_ADDR = 2'(4 * REG_MAX_REPLY_LEN);

  typedef logic [7:0] octets_t [$];
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HALF} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ahfc_in_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ahfc_out_t   out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int results_due;

  int unsigned cycles = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  logic        hold_req = 1'b0;
  int          hold_cnt = 0;
  stall_mode_t mode = STALL_NONE;
  int          mode_left = 0;
  logic [15:0] lens [4];

  always #1 clk = ~clk;

  ascii_hex_frame_codec u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ahfc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("ascii_hex_frame_codec: mismatch");
      $finish;
    end
  end

  // result side: one long hold-off on request, else a changing stall pattern
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt  <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode      <= stall_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(4, 40);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'($urandom);
      endcase
    end
  end

  // offer one word, idling first when a burst is used up
  task automatic offer_word(input logic fn, input logic [7:0] dat, input logic lst);
    ahfc_in_t w;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    w.func = fn;
    w.data = dat;
    w.last = lst;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hex character for a nibble, letters in either case
  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return (($urandom_range(0, 3) == 0) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
  endfunction

  task automatic send_command(input octets_t cmd, input bit close);
    foreach (cmd[i]) offer_word(FUNC_ENCODE, cmd[i], close && (i == cmd.size() - 1));
  endtask

  task automatic send_noise(input int n);
    repeat (n) offer_word(1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // reply frame: header, payload, check; keep limits the bytes sent
  task automatic send_reply(input bit ext, input logic [15:0] dlen, input int npay,
                            input int keep, input bit bad_hdr, input bit bad_chk,
                            input bit odd, input bit close);
    octets_t body;
    logic [7:0] chk;
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    if (ext) begin
      body.push_back(LEN_EXTEND);
      body.push_back(dlen[15:8]);
      body.push_back(dlen[7:0]);
    end else begin
      body.push_back(dlen[7:0]);
    end
    repeat (npay) body.push_back(8'($urandom));
    chk = 8'd0;
    foreach (body[i]) chk = chk ^ body[i];
    if (bad_chk) chk = chk ^ 8'(1 << $urandom_range(0, 7));
    body.push_back(chk);
    offer_word(FUNC_DECODE, bad_hdr ? 8'($urandom_range(4, 255)) : CH_STX, 1'($urandom));
    for (int i = 0; i < body.size() && i < keep; i++) begin
      offer_word(FUNC_DECODE, digit_char(body[i][7:4]), 1'($urandom));
      offer_word(FUNC_DECODE, digit_char(body[i][3:0]), 1'($urandom));
    end
    if (odd) offer_word(FUNC_DECODE, digit_char(4'($urandom)), 1'($urandom));
    if (close) offer_word(FUNC_DECODE, CH_ETX, 1'($urandom));
  endtask

  // mostly well-formed frames, some broken ones and some noise
  task automatic random_frame();
    octets_t cmd;
    int pick;
    int n;
    bit ext;
    logic [15:0] dlen;
    pick = $urandom_range(0, 19);
    if (pick < 7) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      repeat (n) cmd.push_back(8'($urandom));
      // one in seven stays open and gets abandoned by what follows
      send_command(cmd, pick != 0);
    end else if (pick < 17) begin
      ext  = ($urandom_range(0, 3) == 0);
      dlen = 16'($urandom_range(0, 6));
      if (ext && $urandom_range(0, 2) == 0) dlen = 16'($urandom);
      n = (dlen > 16'd8 || $urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : int'(dlen);
      send_reply(ext, dlen, n, ALL_BYTES, pick == 14, pick == 15, pick == 16, 1'b1);
    end else if (pick < 19) begin
      send_noise($urandom_range(1, 10));
    end else begin
      // cut-off reply, closed early or left open
      send_reply(1'b0, 16'd2, 2, $urandom_range(0, 4), 1'b0, 1'b0,
                 1'($urandom), 1'($urandom));
    end
  endtask

  // wait until every due result is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    octets_t cmd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // long hold-off on the result side while the first frames go in
    hold_req <= 1'b1;

    // directed frames at the reset value of max_reply_len
    cmd = {8'h00};
    send_command(cmd, 1'b1);
    cmd = {8'hff, 8'ha5, 8'h5a};
    send_command(cmd, 1'b1);
    send_reply(1'b1, 16'd3, 5, ALL_BYTES, 1'b0, 1'b0, 1'b0, 1'b1);
    send_reply(1'b0, 16'd0, 0, ALL_BYTES, 1'b1, 1'b0, 1'b0, 1'b1);
    send_reply(1'b0, 16'd5, 2, ALL_BYTES, 1'b0, 1'b1, 1'b0, 1'b1);
    send_reply(1'b0, 16'd1, 1, ALL_BYTES, 1'b0, 1'b0, 1'b1, 1'b1);
    send_reply(1'b0, 16'd2, 2, 1, 1'b0, 1'b0, 1'b0, 1'b1);
    offer_word(FUNC_DECODE, CH_ETX, 1'b1);
    // mode changes in the middle of a frame
    cmd = {8'h11, 8'h22};
    send_command(cmd, 1'b0);
    send_reply(1'b0, 16'd0, 0, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    cmd = {8'h80};
    send_command(cmd, 1'b1);
    // non-hex characters go through the lenient digit rule
    cmd = {CH_STX, "G", "z", 8'h00, 8'hff, CH_STX, "g", "/", ":", "@", "F", "f"};
    foreach (cmd[i]) offer_word(FUNC_DECODE, cmd[i], 1'b0);
    offer_word(FUNC_DECODE, CH_ETX, 1'b0);

    // random frames over several payload caps, extremes included
    lens[0] = 16'd0;
    lens[1] = 16'd2;
    lens[2] = 16'($urandom_range(3, 300));
    lens[3] = 16'hffff;
    foreach (lens[s]) begin
      settle();
      write_max_len(lens[s]);
      do random_frame(); while (items_sent < ITEM_TARGET * (s + 1) / 4);
    end

    settle();
    if (fail_count == 0) begin
      $display("ascii_hex_frame_codec: match");
    end else begin
      $display("ascii_hex_frame_codec: mismatch");
    end
    $finish;
  end

endmodule

### ascii_hex_frame_codec.f
sv/ahfc_pkg.sv
sv/ascii_hex_frame_codec.sv
tb/ahfc_checker.sv
tb/testbench.sv
